>>> hw/rtl/dbs_pkg.sv
// dbs_pkg: shared types, constants and the delimiter encoder of the delimiter byte segmenter
// used by every module of the block; depends on nothing

package dbs_pkg;

    localparam int OFS_W     = 17;
    localparam int CP_W      = 21;
    localparam int CFG_IDX_W = 1;

    localparam logic [OFS_W-1:0] MAX_TEXT      = 17'd65536;
    localparam logic [CP_W-1:0]  DEFAULT_DELIM = 21'h002581;
    localparam logic [CP_W-1:0]  CP_MAX_1B     = 21'h00007F;
    localparam logic [CP_W-1:0]  CP_MAX_2B     = 21'h0007FF;
    localparam logic [CP_W-1:0]  CP_MAX_3B     = 21'h00FFFF;
    localparam logic [CP_W-1:0]  CP_MAX_4B     = 21'h10FFFF;
    localparam logic [CP_W-1:0]  SPLIT_RESET   = 21'd1;

    // queue between front and back, depth must be a power of two
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIM = 1'b0,
        CFG_SPLIT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [OFS_W-1:0] segment_begin;
        logic [OFS_W-1:0] segment_finish;
        logic             final_segment;
        logic             length_overflow;
    } t_out_item;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } t_delim;

    // per byte outcome: an optional inner segment and an optional final one
    typedef struct packed {
        logic             has_a;
        logic [OFS_W-1:0] a_begin;
        logic [OFS_W-1:0] a_finish;
        logic             has_b;
        logic [OFS_W-1:0] b_begin;
        logic [OFS_W-1:0] b_finish;
        logic             ovf;
    } t_seg_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic t_delim encode_delim(input logic [CP_W-1:0] cp_in);
        logic [CP_W-1:0] cp;
        t_delim          d;
        cp      = (cp_in == '0) ? DEFAULT_DELIM : cp_in;
        d.bytes = '0;
        if (cp <= CP_MAX_1B) begin
            d.len      = 3'd1;
            d.bytes[0] = cp[7:0];
        end else if (cp <= CP_MAX_2B) begin
            d.len      = 3'd2;
            d.bytes[0] = {3'b110, cp[10:6]};
            d.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= CP_MAX_3B) begin
            d.len      = 3'd3;
            d.bytes[0] = {4'b1110, cp[15:12]};
            d.bytes[1] = {2'b10, cp[11:6]};
            d.bytes[2] = {2'b10, cp[5:0]};
        end else if (cp <= CP_MAX_4B) begin
            d.len      = 3'd4;
            d.bytes[0] = {5'b11110, cp[20:18]};
            d.bytes[1] = {2'b10, cp[17:12]};
            d.bytes[2] = {2'b10, cp[11:6]};
            d.bytes[3] = {2'b10, cp[5:0]};
        end else begin
            d.len = 3'd0;
        end
        return d;
    endfunction

endpackage

>>> hw/rtl/dbs_front.sv
// dbs_front: takes text bytes, runs the delimiter match and segment state,
// and pushes per byte segment commands into the queue; depends on dbs_pkg

module dbs_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  dbs_pkg::t_in_item                    i_in_data,
    output logic                                 o_in_stall,
    input  logic                                 i_cfg_we,
    input  logic [dbs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [dbs_pkg::CP_W-1:0]             i_cfg_data,
    input  dbs_pkg::t_q_status                   i_q_status,
    output logic                                 o_push,
    output dbs_pkg::t_seg_cmd                    o_push_data
);

    logic [dbs_pkg::OFS_W-1:0] r_pos, n_pos;
    logic [dbs_pkg::OFS_W-1:0] r_os, n_os;
    logic                      r_so, n_so;
    logic [1:0]                r_mp, n_mp;
    logic                      r_ovf, n_ovf;
    dbs_pkg::t_delim           r_delim, n_delim;
    logic                      r_split, n_split;

    logic                      in_fire;
    logic [dbs_pkg::OFS_W-1:0] v_cur, v_nxt, v_dstart;
    logic                      v_found, v_fresh;
    dbs_pkg::t_seg_cmd         v_cmd;

    function automatic logic [dbs_pkg::OFS_W-1:0] sat_sub(
        input logic [dbs_pkg::OFS_W-1:0] a,
        input logic [1:0]                k
    );
        logic [dbs_pkg::OFS_W-1:0] kk;
        kk = {{(dbs_pkg::OFS_W-2){1'b0}}, k};
        return (a >= kk) ? (a - kk) : '0;
    endfunction

    assign o_in_stall = i_q_status.full;
    assign in_fire    = i_in_valid && !i_q_status.full;

    always_comb begin
        n_pos    = r_pos;
        n_os     = r_os;
        n_so     = r_so;
        n_mp     = r_mp;
        n_ovf    = r_ovf;
        n_delim  = r_delim;
        n_split  = r_split;
        v_cur    = r_pos;
        v_nxt    = r_pos;
        v_dstart = '0;
        v_found  = 1'b0;
        v_fresh  = 1'b1;
        v_cmd    = '0;
        o_push   = 1'b0;

        if (in_fire) begin
            // position saturates at the text limit and flags overflow
            if (r_pos >= dbs_pkg::MAX_TEXT) begin
                v_cur = dbs_pkg::MAX_TEXT;
                v_nxt = dbs_pkg::MAX_TEXT;
                n_ovf = 1'b1;
            end else begin
                v_nxt = r_pos + 1'b1;
            end

            if (r_split && r_delim.len != 3'd0) begin
                if (n_mp != 2'd0 && {1'b0, n_mp} < r_delim.len) begin
                    if (i_in_data.text_byte == r_delim.bytes[n_mp]) begin
                        v_fresh = 1'b0;
                        if (({1'b0, n_mp} + 3'd1) >= r_delim.len) begin
                            v_found  = 1'b1;
                            v_dstart = sat_sub(v_cur, 2'(r_delim.len - 3'd1));
                        end
                        n_mp = n_mp + 2'd1;
                    end else begin
                        // broken partial match turns into content
                        if (!n_so) begin
                            n_so = 1'b1;
                            n_os = sat_sub(v_cur, n_mp);
                        end
                        n_mp = 2'd0;
                    end
                end else begin
                    n_mp = 2'd0;
                end

                if (v_fresh) begin
                    if (i_in_data.text_byte == r_delim.bytes[0]) begin
                        if (r_delim.len == 3'd1) begin
                            v_found  = 1'b1;
                            v_dstart = v_cur;
                        end else begin
                            n_mp = 2'd1;
                        end
                    end else if (!n_so) begin
                        n_so = 1'b1;
                        n_os = v_cur;
                    end
                end

                if (v_found) begin
                    n_mp = 2'd0;
                    if (n_so && n_os < v_dstart) begin
                        v_cmd.has_a    = 1'b1;
                        v_cmd.a_begin  = n_os;
                        v_cmd.a_finish = v_dstart;
                    end
                    n_os = v_dstart;
                    n_so = 1'b1;
                end
            end else begin
                n_mp = 2'd0;
                if (!n_so) begin
                    n_so = 1'b1;
                    n_os = v_cur;
                end
            end

            n_pos     = v_nxt;
            v_cmd.ovf = n_ovf;

            if (i_in_data.end_of_text) begin
                // dangling partial match is content of the last segment
                if (n_mp != 2'd0) begin
                    if (!n_so) begin
                        n_so = 1'b1;
                        n_os = sat_sub(v_nxt, n_mp);
                    end
                    n_mp = 2'd0;
                end
                if (!n_so) begin
                    n_os = v_cur;
                end
                v_cmd.has_b    = 1'b1;
                v_cmd.b_begin  = n_os;
                v_cmd.b_finish = v_nxt;
                n_pos = '0;
                n_os  = '0;
                n_so  = 1'b0;
                n_mp  = 2'd0;
                n_ovf = 1'b0;
            end

            o_push = v_cmd.has_a || v_cmd.has_b;
        end else if (i_cfg_we) begin
            if (n_mp != 2'd0) begin
                if (!n_so) begin
                    n_so = 1'b1;
                    n_os = sat_sub(r_pos, n_mp);
                end
                n_mp = 2'd0;
            end
            case (dbs_pkg::t_cfg_idx'(i_cfg_idx))
                dbs_pkg::CFG_DELIM: n_delim = dbs_pkg::encode_delim(i_cfg_data);
                dbs_pkg::CFG_SPLIT: n_split = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_push_data = v_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_os    <= '0;
            r_so    <= 1'b0;
            r_mp    <= 2'd0;
            r_ovf   <= 1'b0;
            r_delim <= dbs_pkg::encode_delim(dbs_pkg::DEFAULT_DELIM);
            r_split <= dbs_pkg::SPLIT_RESET[0];
        end else begin
            r_pos   <= n_pos;
            r_os    <= n_os;
            r_so    <= n_so;
            r_mp    <= n_mp;
            r_ovf   <= n_ovf;
            r_delim <= n_delim;
            r_split <= n_split;
        end
    end

endmodule

>>> hw/rtl/dbs_queue.sv
// dbs_queue: small flop queue of segment commands between front and back
// depends on dbs_pkg for the command type and depth

module dbs_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dbs_pkg::t_seg_cmd   i_push_data,
    input  logic                i_pop,
    output dbs_pkg::t_seg_cmd   o_head,
    output dbs_pkg::t_q_status  o_status
);

    dbs_pkg::t_seg_cmd          r_mem [dbs_pkg::QDEPTH];
    logic [dbs_pkg::QPTR_W-1:0] r_wr, n_wr;
    logic [dbs_pkg::QPTR_W-1:0] r_rd, n_rd;
    logic [dbs_pkg::QCNT_W-1:0] r_cnt, n_cnt;

    assign o_status.full  = (r_cnt == dbs_pkg::QCNT_W'(dbs_pkg::QDEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_head         = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> hw/rtl/dbs_back.sv
// dbs_back: expands queued segment commands into one result beat per cycle, while the output
// is not stalled, through the output register; depends on dbs_pkg

module dbs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dbs_pkg::t_seg_cmd   i_head,
    input  dbs_pkg::t_q_status  i_q_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dbs_pkg::t_out_item  o_out_data
);

    logic               r_out_valid, n_out_valid;
    dbs_pkg::t_out_item r_out, n_out;
    logic               r_half, n_half;
    logic               load;

    assign load = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_half      = r_half;
        o_pop       = 1'b0;
        if (load) begin
            n_out_valid = !i_q_status.empty;
            if (!i_q_status.empty) begin
                n_out.length_overflow = i_head.ovf;
                if (i_head.has_a && !r_half) begin
                    n_out.segment_begin  = i_head.a_begin;
                    n_out.segment_finish = i_head.a_finish;
                    n_out.final_segment  = 1'b0;
                    // keep the entry when its final segment is still to go
                    n_half = i_head.has_b;
                    o_pop  = !i_head.has_b;
                end else begin
                    n_out.segment_begin  = i_head.b_begin;
                    n_out.segment_finish = i_head.b_finish;
                    n_out.final_segment  = 1'b1;
                    n_half = 1'b0;
                    o_pop  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_half      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_half      <= n_half;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hw/rtl/delimiter_byte_segmenter.sv
// delimiter_byte_segmenter: top level, front matcher, command queue and result stage
// depends on dbs_pkg, dbs_front, dbs_queue and dbs_back
// a result beat passes a queue entry, then the output register, after its byte is taken
// one byte per cycle while the queue has room; one result beat per cycle while not stalled
// a byte that yields two segments takes two output beats, the four entry queue absorbs that
// reset: synchronous active low, clears match state, queue and output valid; no clearing pass

module delimiter_byte_segmenter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  dbs_pkg::t_in_item             i_in_data,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output dbs_pkg::t_out_item            o_out_data,
    input  logic                          i_out_stall,
    input  logic                          i_cfg_we,
    input  logic [dbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dbs_pkg::CP_W-1:0]      i_cfg_data
);

    logic               push;
    dbs_pkg::t_seg_cmd  push_data;
    logic               pop;
    dbs_pkg::t_seg_cmd  head;
    dbs_pkg::t_q_status q_status;

    dbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    dbs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    dbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> hw/rtl/dbs_checker.sv
// dbs_port_checks: port level checks on the delimiter byte segmenter, bound to the top level
// depends on dbs_pkg and delimiter_byte_segmenter

module dbs_port_checks (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input dbs_pkg::t_out_item o_out_data
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    // inner segments are never empty
    a_inner_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.final_segment |->
            o_out_data.segment_begin < o_out_data.segment_finish)
        else $error("inner segment empty or reversed");

    a_final_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.final_segment |->
            o_out_data.segment_begin <= o_out_data.segment_finish)
        else $error("final segment reversed");

    // offsets never pass the saturation point
    a_finish_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.segment_finish <= dbs_pkg::MAX_TEXT)
        else $error("segment end beyond text limit");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind delimiter_byte_segmenter dbs_port_checks u_dbs_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

>>> test/dbs_checker.sv
// dbs_checker: watches the byte and segment channels of the delimiter byte segmenter,
// predicts every segment beat from accepted bytes and register writes, and compares them
// depends on dbs_pkg for the beat and register types

module dbs_checker
    import dbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in_item             i_in_data,
    input  logic                 i_in_stall,
    input  logic                 i_out_valid,
    input  t_out_item            i_out_data,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CP_W-1:0]      i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_seg_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    // register mirror and the delimiter bytes it selects
    logic [CP_W-1:0]       delim_cp;
    logic                  split_on;
    logic [2:0]            dl_len;
    logic [3:0][7:0]       dl_bytes;

    // segmenter state
    logic [OFS_W-1:0]      txt_pos;
    logic [OFS_W-1:0]      seg_start;
    logic                  seg_open;
    logic [2:0]            mprog;
    logic                  ovf_seen;

    t_out_item             seg_expect[$];
    int                    fails;
    int                    checked;

    function automatic logic [OFS_W-1:0] sat_sub(input logic [OFS_W-1:0] a,
                                                 input logic [OFS_W-1:0] b);
        return (a >= b) ? a - b : '0;
    endfunction

    function automatic string seg_text(input t_out_item s);
        return $sformatf("[%0d,%0d) final %0d overflow %0d", s.segment_begin,
                         s.segment_finish, s.final_segment, s.length_overflow);
    endfunction

    task automatic load_delim();
        logic [CP_W-1:0] cp;
        cp       = (delim_cp == '0) ? DEFAULT_DELIM : delim_cp;
        dl_bytes = '0;
        if (cp <= CP_MAX_1B) begin
            dl_len      = 3'd1;
            dl_bytes[0] = cp[7:0];
        end else if (cp <= CP_MAX_2B) begin
            dl_len      = 3'd2;
            dl_bytes[0] = 8'hC0 | 8'(cp >> 6);
            dl_bytes[1] = 8'h80 | 8'(cp & 21'h3F);
        end else if (cp <= CP_MAX_3B) begin
            dl_len      = 3'd3;
            dl_bytes[0] = 8'hE0 | 8'(cp >> 12);
            dl_bytes[1] = 8'h80 | 8'((cp >> 6) & 21'h3F);
            dl_bytes[2] = 8'h80 | 8'(cp & 21'h3F);
        end else if (cp <= CP_MAX_4B) begin
            dl_len      = 3'd4;
            dl_bytes[0] = 8'hF0 | 8'(cp >> 18);
            dl_bytes[1] = 8'h80 | 8'((cp >> 12) & 21'h3F);
            dl_bytes[2] = 8'h80 | 8'((cp >> 6) & 21'h3F);
            dl_bytes[3] = 8'h80 | 8'(cp & 21'h3F);
        end else begin
            // no encoding, nothing ever matches
            dl_len = 3'd0;
        end
    endtask

    task automatic clear_text();
        txt_pos   = '0;
        seg_start = '0;
        seg_open  = 1'b0;
        mprog     = '0;
        ovf_seen  = 1'b0;
    endtask

    // matched bytes of a broken partial match become content
    task automatic flush_partial(input logic [OFS_W-1:0] base);
        if (mprog != 0) begin
            if (!seg_open) begin
                seg_open  = 1'b1;
                seg_start = sat_sub(base, OFS_W'(mprog));
            end
            mprog = '0;
        end
    endtask

    task automatic push_seg(input logic [OFS_W-1:0] b, input logic [OFS_W-1:0] f,
                            input logic fin);
        t_out_item s;
        s.segment_begin   = b;
        s.segment_finish  = f;
        s.final_segment   = fin;
        s.length_overflow = ovf_seen;
        seg_expect.push_back(s);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CP_W-1:0] data);
        flush_partial(txt_pos);
        case (idx)
            CFG_DELIM: begin
                delim_cp = data;
                load_delim();
            end
            CFG_SPLIT: begin
                split_on = data[0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic segment_byte(input t_in_item it);
        logic [OFS_W-1:0] cur;
        logic [OFS_W-1:0] nxt;
        logic [OFS_W-1:0] dstart;
        logic             found;
        logic             fresh;
        cur    = txt_pos;
        dstart = '0;
        found  = 1'b0;
        fresh  = 1'b1;
        if (cur >= MAX_TEXT) begin
            cur      = MAX_TEXT;
            ovf_seen = 1'b1;
            nxt      = cur;
        end else begin
            nxt = cur + 1'b1;
        end

        if (split_on && dl_len != 0) begin
            if (mprog != 0 && mprog < dl_len) begin
                if (it.text_byte == dl_bytes[mprog[1:0]]) begin
                    mprog = mprog + 1'b1;
                    fresh = 1'b0;
                    if (mprog >= dl_len) begin
                        found  = 1'b1;
                        dstart = sat_sub(cur, OFS_W'(dl_len - 3'd1));
                    end
                end else begin
                    flush_partial(cur);
                end
            end else begin
                mprog = '0;
            end
            // the current byte may start a new match
            if (fresh) begin
                if (it.text_byte == dl_bytes[0]) begin
                    if (dl_len == 3'd1) begin
                        found  = 1'b1;
                        dstart = cur;
                    end else begin
                        mprog = 3'd1;
                    end
                end else if (!seg_open) begin
                    seg_open  = 1'b1;
                    seg_start = cur;
                end
            end
            if (found) begin
                mprog = '0;
                if (seg_open && seg_start < dstart)
                    push_seg(seg_start, dstart, 1'b0);
                seg_start = dstart;
                seg_open  = 1'b1;
            end
        end else begin
            mprog = '0;
            if (!seg_open) begin
                seg_open  = 1'b1;
                seg_start = cur;
            end
        end

        txt_pos = nxt;
        if (it.end_of_text) begin
            flush_partial(nxt);
            if (!seg_open) begin
                seg_open  = 1'b1;
                seg_start = cur;
            end
            push_seg(seg_start, nxt, 1'b1);
            clear_text();
        end
    endtask

    task automatic note_failure(input string msg);
        fails++;
        if (fails <= REPORT_MAX)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic check_beat(input t_out_item got);
        t_out_item want;
        checked++;
        if (seg_expect.size() == 0) begin
            note_failure({"segment beat with nothing expected: ", seg_text(got)});
        end else begin
            want = seg_expect.pop_front();
            if (got.segment_begin !== want.segment_begin ||
                got.segment_finish !== want.segment_finish ||
                got.final_segment !== want.final_segment ||
                got.length_overflow !== want.length_overflow)
                note_failure({"segment mismatch: expected ", seg_text(want),
                              " got ", seg_text(got)});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            delim_cp = DEFAULT_DELIM;
            split_on = 1'b1;
            load_delim();
            clear_text();
            seg_expect.delete();
        end else begin
            if (i_cfg_we)
                write_reg(t_cfg_idx'(i_cfg_idx), i_cfg_data);
            if (i_in_valid && !i_in_stall)
                segment_byte(i_in_data);
            if (i_out_valid && !i_out_stall)
                check_beat(i_out_data);
        end
        o_pending    <= seg_expect.size();
        o_fail_count <= fails;
        o_seg_count  <= checked;
    end

endmodule

>>> test/testbench.sv
// testbench: drives text bytes and register writes into delimiter_byte_segmenter
// and gives the verdict; segment checking lives in dbs_checker
// depends on dbs_pkg, dbs_checker and the segmenter RTL

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dbs_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int WD_LIMIT     = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 118;
    localparam int WARM_ITEMS   = 24;

    // opening bytes as {end_of_text, byte}; delimiter is the reset U+2581 (E2 96 81)
    localparam logic [0:WARM_ITEMS-1][8:0] WARM = {
        9'h000, 9'h0FF, 9'h0E2, 9'h096, 9'h081, 9'h0E2, 9'h096, 9'h081,
        9'h061, 9'h0E2, 9'h096, 9'h0E2, 9'h096, 9'h181, 9'h141, 9'h0E2,
        9'h196, 9'h0E2, 9'h0E2, 9'h096, 9'h181, 9'h063, 9'h0E2, 9'h096
    };

    typedef enum logic [2:0] {
        MODE_FREE,
        MODE_SRC_IDLE,
        MODE_SNK_STALL,
        MODE_BOTH,
        MODE_PRESSURE
    } t_mode;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_item             in_data   = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_out_item            out_data;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = CFG_DELIM;
    logic [CP_W-1:0]      cfg_data  = '0;

    t_mode                mode      = MODE_FREE;
    int                   src_idle_pct;
    t_delim               cur_delim;
    int                   bytes_sent;
    int                   settings_run;
    int                   hold_left;
    logic                 hold_done = 1'b0;
    int                   quiet;

    int                   chk_fail;
    int                   chk_pending;
    int                   chk_segs;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    delimiter_byte_segmenter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    dbs_checker seg_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_data    (in_data),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_data   (out_data),
        .i_out_stall  (out_stall),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (chk_fail),
        .o_pending    (chk_pending),
        .o_seg_count  (chk_segs)
    );

    // segment side: random stall, plus one long hold-off in the pressure phase
    always @(posedge clk) begin : segment_sink
        int pct;
        case (mode)
            MODE_SNK_STALL: pct = 80;
            MODE_BOTH:      pct = 37;
            default:        pct = 0;
        endcase
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (mode == MODE_PRESSURE && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet + 1 >= WD_LIMIT) begin
                $display("no beat moved for %0d cycles", WD_LIMIT);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        t_in_item it;
        int       gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.text_byte   = b;
        it.end_of_text = eot;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CP_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly pieces of the delimiter (whole, broken prefixes, single bytes), the rest plain bytes
    task automatic run_items(input int count);
        logic [7:0] tok[$];
        int         left;
        int         r;
        int         n;
        int         m;
        left = count;
        while (left > 0) begin
            tok.delete();
            r = $urandom_range(99);
            n = int'(cur_delim.len);
            if (n != 0 && r < 35) begin
                for (int k = 0; k < n; k++)
                    tok.push_back(cur_delim.bytes[k]);
            end else if (n > 1 && r < 47) begin
                m = $urandom_range(n - 1, 1);
                for (int k = 0; k < m; k++)
                    tok.push_back(cur_delim.bytes[k]);
            end else if (n != 0 && r < 62) begin
                tok.push_back(cur_delim.bytes[$urandom_range(n - 1)]);
            end else begin
                tok.push_back(8'($urandom_range(255)));
            end
            foreach (tok[k]) begin
                if (left > 0) begin
                    send_byte(tok[k], $urandom_range(99) < 8);
                    left--;
                end
            end
        end
    endtask

    task automatic run_phase(input logic [CP_W-1:0] cp, input logic split,
                             input t_mode m, input int n);
        logic [CP_W-1:0] split_word;
        // upper bits of the split word are don't care
        split_word = CP_W'({$urandom(), split});
        cfg_write(CFG_DELIM, cp);
        cfg_write(CFG_SPLIT, split_word);
        cur_delim = encode_delim(cp);
        mode <= m;
        case (m)
            MODE_SRC_IDLE: src_idle_pct = 80;
            MODE_BOTH:     src_idle_pct = 37;
            default:       src_idle_pct = 0;
        endcase
        settings_run++;
        run_items(n);
        settle();
    endtask

    initial begin
        int fails;
        cur_delim    = encode_delim(DEFAULT_DELIM);
        src_idle_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ends on a dangling prefix, flushed by the next register write
        for (int i = 0; i < WARM_ITEMS; i++)
            send_byte(WARM[i][7:0], WARM[i][8]);
        settle();

        run_phase(21'h000000, 1'b1, MODE_FREE,      PHASE_ITEMS);
        run_phase(21'h000020, 1'b1, MODE_SRC_IDLE,  PHASE_ITEMS);
        run_phase(21'h00007F, 1'b1, MODE_SNK_STALL, PHASE_ITEMS);
        run_phase(21'h000080, 1'b1, MODE_BOTH,      PHASE_ITEMS);
        run_phase(21'h0007FF, 1'b1, MODE_PRESSURE,  PHASE_ITEMS);
        run_phase(21'h000800, 1'b1, MODE_FREE,      PHASE_ITEMS);
        run_phase(21'h00D800, 1'b1, MODE_SRC_IDLE,  PHASE_ITEMS);
        run_phase(21'h00FFFF, 1'b1, MODE_SNK_STALL, PHASE_ITEMS);
        run_phase(21'h010000, 1'b1, MODE_BOTH,      PHASE_ITEMS);
        run_phase(21'h10FFFF, 1'b1, MODE_FREE,      PHASE_ITEMS);
        run_phase(21'h1FFFFF, 1'b1, MODE_BOTH,      PHASE_ITEMS);
        run_phase(21'h002581, 1'b0, MODE_SRC_IDLE,  PHASE_ITEMS);
        run_phase(CP_W'($urandom_range(21'h10FFFF)), 1'($urandom_range(1)),
                  MODE_BOTH, PHASE_ITEMS);
        run_phase(21'h00007F, 1'b0, MODE_SNK_STALL, PHASE_ITEMS);

        fails = chk_fail + chk_pending;
        $display("covered %0d text bytes under %0d register settings, 1 to 4 byte delimiters",
                 bytes_sent, settings_run);
        $display("compared %0d segment beats under idle, stall and hold-off, %0d failures",
                 chk_segs, fails);
        if (fails == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/dbs_pkg.sv
hw/rtl/dbs_front.sv
hw/rtl/dbs_queue.sv
hw/rtl/dbs_back.sv
hw/rtl/delimiter_byte_segmenter.sv
hw/rtl/dbs_checker.sv
test/dbs_checker.sv
test/testbench.sv
